/* src/c1d_pkg.sv */
// Shared types, constants and helpers for the 1D convolution core.
package c1d_pkg;

  localparam int MAX_IN_CH  = 16;
  localparam int MAX_OUT_CH = 16;
  localparam int MAX_TAPS   = 16;
  localparam int MAX_STRIDE = 16;
  localparam int MAX_FRAME  = 4096;

  localparam int W_DEPTH   = MAX_OUT_CH * MAX_IN_CH * MAX_TAPS;
  localparam int WIN_DEPTH = MAX_TAPS * MAX_IN_CH;
  localparam int W_AW      = $clog2(W_DEPTH);
  localparam int WIN_AW    = $clog2(WIN_DEPTH);
  localparam int CH_W      = $clog2(MAX_IN_CH);
  localparam int TAP_W     = $clog2(MAX_TAPS);
  localparam int ACC_W     = 40;

  typedef enum logic [1:0] {
    FUNC_WEIGHT = 2'd0,
    FUNC_BIAS   = 2'd1,
    FUNC_SAMPLE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_IN_CH   = 3'd0,
    REG_OUT_CH  = 3'd1,
    REG_TAPS    = 3'd2,
    REG_STRIDE  = 3'd3,
    REG_FRAME   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]         func;
    logic [11:0]        store_index;
    logic signed [15:0] item_value;
    logic               frame_start;
  } item_t;

  typedef struct packed {
    logic [3:0]         out_channel;
    logic [11:0]        out_position;
    logic signed [15:0] out_value;
    logic               saturated;
    logic               last;
  } result_t;

  typedef struct packed {
    logic init;
    logic mul_en;
  } mac_ctl_t;

  function automatic logic [4:0] clamp5(input logic [4:0] v, input logic [4:0] hi);
    logic [4:0] r;
    if (v == 5'd0) r = 5'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [12:0] clamp13(input logic [12:0] v);
    logic [12:0] r;
    if (v == 13'd0) r = 13'd1;
    else if (v > 13'(MAX_FRAME)) r = 13'(MAX_FRAME);
    else r = v;
    return r;
  endfunction

endpackage

/* src/c1d_rem.sv */
// Iterative remainder unit: one restoring compare-subtract step per cycle.
module c1d_rem import c1d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [11:0] dividend,
  input  logic [4:0]  divisor,
  output logic        done,
  output logic [3:0]  rem
);

  logic [11:0] shreg;
  logic [4:0]  dvs;
  logic [3:0]  cnt;
  logic        busy;
  logic [4:0]  trial;
  logic [4:0]  rem_next;

  always_comb begin
    trial = {rem, shreg[11]};
    rem_next = (trial >= dvs) ? trial - dvs : trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= '0;
        shreg <= dividend;
        dvs   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        rem   <= rem_next[3:0];
        shreg <= {shreg[10:0], 1'b0};
        cnt   <= cnt + 4'd1;
        if (cnt == 4'd11) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* src/c1d_mac.sv */
// Shared multiply-accumulate unit with Q8.8 rescale and saturation.
module c1d_mac import c1d_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mac_ctl_t           ctl,
  input  logic signed [15:0] bias,
  input  logic signed [15:0] w,
  input  logic signed [15:0] x,
  output logic               busy,
  output logic signed [15:0] value,
  output logic               sat
);

  logic signed [31:0]      prod;
  logic                    prod_v;
  logic signed [ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_v <= 1'b0;
    end else begin
      prod_v <= ctl.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    prod <= w * x;
    if (ctl.init) begin
      acc <= {{16{bias[15]}}, bias, 8'd0};
    end else if (prod_v) begin
      acc <= acc + {{8{prod[31]}}, prod};
    end
  end

  // floor shift by 8 keeps acc[39:8]; it fits 16 bits when bits 39..23 agree
  always_comb begin
    busy = prod_v;
    sat  = !((&acc[39:23]) || !(|acc[39:23]));
    if (sat) value = acc[39] ? 16'sh8000 : 16'sh7fff;
    else value = acc[23:8];
  end

endmodule

/* src/conv1d_forward_multichannel_core.sv */
// Top level: config registers, stores, sequencer and result register of the conv core.
//  channel  | handshake                   | payload
//  item     | item_valid / item_stall     | item (item_t)
//  result   | result_valid / result_stall | result (result_t)
//  config   | psel/penable/pwrite/pready  | paddr, pwdata, prdata
// Weight, bias and func 3 items are accepted in idle; a sample stalls the item port
// until it is handled. A sample ending a window issues, per output channel,
// in_channels*kernel_taps products to the single shared multiplier, one per cycle.
// Sync reset clears frame counters and window valid bits, presets config; no clearing pass.
// A result waits in the output register while result_stall is high; the sequencer holds.
module conv1d_forward_multichannel_core import c1d_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_REM, ST_BIAS, ST_ISSUE, ST_DRAIN, ST_EMIT
  } state_t;

  state_t state;

  logic [4:0]  cfg_ic, cfg_oc, cfg_k, cfg_s;
  logic [12:0] cfg_fl;
  logic [4:0]  ic, oc, k, s;
  logic [12:0] fl;

  logic [11:0] position_count, window_index;
  logic [3:0]  channel_count, stride_phase;

  logic [11:0] p_cur;
  logic [3:0]  ch_cur;
  logic signed [15:0] cur_val;
  logic [11:0] out_pos;
  logic [3:0]  slot_start, slot, t_cnt, i_cnt, o_cnt;
  logic [11:0] waddr;
  logic        s1_v;

  logic signed [15:0] weight_mem [W_DEPTH];
  logic signed [15:0] win_mem [WIN_DEPTH];
  logic [WIN_DEPTH-1:0] win_vld;
  logic signed [15:0] bias_mem [MAX_OUT_CH];
  logic signed [15:0] rd_w, rd_x;
  logic        rd_xv;

  logic        item_acc, w_we, b_we, x_we, cfg_we, res_load;
  logic        rem_start, rem_done;
  logic [3:0]  rem_val, slot_inc;
  logic [11:0] rem_dividend;
  logic        ch_ok, ch_more, p_full, win_hit, frame_end;
  logic        t_last, i_last, o_last;
  logic signed [15:0] mac_value;
  logic        mac_sat, mac_busy;
  mac_ctl_t    mac_ctl;

  // configuration
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_ic <= 5'd1;
      cfg_oc <= 5'd1;
      cfg_k  <= 5'd1;
      cfg_s  <= 5'd1;
      cfg_fl <= 13'd16;
    end else if (cfg_we) begin
      unique case (paddr[4:2])
        REG_IN_CH:  cfg_ic <= pwdata[4:0];
        REG_OUT_CH: cfg_oc <= pwdata[4:0];
        REG_TAPS:   cfg_k  <= pwdata[4:0];
        REG_STRIDE: cfg_s  <= pwdata[4:0];
        REG_FRAME:  cfg_fl <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_IN_CH:  prdata = {27'd0, cfg_ic};
      REG_OUT_CH: prdata = {27'd0, cfg_oc};
      REG_TAPS:   prdata = {27'd0, cfg_k};
      REG_STRIDE: prdata = {27'd0, cfg_s};
      REG_FRAME:  prdata = {19'd0, cfg_fl};
      default:    prdata = '0;
    endcase
  end

  assign ic = clamp5(cfg_ic, 5'(MAX_IN_CH));
  assign oc = clamp5(cfg_oc, 5'(MAX_OUT_CH));
  assign k  = clamp5(cfg_k, 5'(MAX_TAPS));
  assign s  = clamp5(cfg_s, 5'(MAX_STRIDE));
  assign fl = clamp13(cfg_fl);

  // control decode
  assign item_stall = (state != ST_IDLE);
  assign item_acc   = item_valid && !item_stall;
  assign w_we = item_acc && (item.func == FUNC_WEIGHT);
  assign b_we = item_acc && (item.func == FUNC_BIAS) && (item.store_index[11:4] == 8'd0);
  assign rem_start = item_acc && (item.func == FUNC_SAMPLE);
  assign rem_dividend = item.frame_start ? 12'd0 : position_count;

  assign ch_ok     = ({1'b0, ch_cur} < ic);
  assign ch_more   = ({1'b0, ch_cur} + 5'd1 < ic);
  assign p_full    = ({1'b0, p_cur} + 13'd1 >= {8'd0, k});
  assign win_hit   = p_full && (stride_phase == 4'd0);
  assign frame_end = ({1'b0, p_cur} + 13'd1 >= fl);
  assign x_we      = (state == ST_REM) && rem_done && ch_ok;
  assign slot_inc  = ({1'b0, rem_val} + 5'd1 == k) ? 4'd0 : rem_val + 4'd1;

  assign t_last = ({1'b0, t_cnt} + 5'd1 == k);
  assign i_last = ({1'b0, i_cnt} + 5'd1 == ic);
  assign o_last = ({1'b0, o_cnt} + 5'd1 == oc);
  assign res_load = (state == ST_EMIT) && (!result_valid || !result_stall);

  c1d_rem u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (rem_dividend),
    .divisor  (k),
    .done     (rem_done),
    .rem      (rem_val)
  );

  // stores
  always_ff @(posedge clk) begin
    if (w_we) weight_mem[item.store_index] <= item.item_value;
    rd_w <= weight_mem[waddr];
  end

  always_ff @(posedge clk) begin
    if (x_we) win_mem[{rem_val, ch_cur}] <= cur_val;
    rd_x  <= win_mem[{slot, i_cnt}];
    rd_xv <= win_vld[{slot, i_cnt}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_vld <= '0;
    end else if (x_we) begin
      win_vld[{rem_val, ch_cur}] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_we) bias_mem[item.store_index[3:0]] <= item.item_value;
  end

  assign mac_ctl.init   = (state == ST_BIAS);
  assign mac_ctl.mul_en = s1_v;

  c1d_mac u_mac (
    .clk   (clk),
    .rst   (rst),
    .ctl   (mac_ctl),
    .bias  (bias_mem[o_cnt]),
    .w     (rd_w),
    .x     (rd_xv ? rd_x : 16'sd0),
    .busy  (mac_busy),
    .value (mac_value),
    .sat   (mac_sat)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      position_count <= '0;
      channel_count  <= '0;
      stride_phase   <= '0;
      window_index   <= '0;
      result_valid   <= 1'b0;
      s1_v           <= 1'b0;
    end else begin
      s1_v <= (state == ST_ISSUE);
      if (res_load) result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (rem_start) begin
            cur_val <= item.item_value;
            if (item.frame_start) begin
              p_cur          <= '0;
              ch_cur         <= '0;
              position_count <= '0;
              channel_count  <= '0;
              stride_phase   <= '0;
              window_index   <= '0;
            end else begin
              p_cur  <= position_count;
              ch_cur <= channel_count;
            end
            state <= ST_REM;
          end
        end
        ST_REM: begin
          if (rem_done) begin
            slot_start <= slot_inc;
            out_pos    <= window_index;
            if (ch_more) begin
              channel_count <= ch_cur + 4'd1;
              state <= ST_IDLE;
            end else begin
              channel_count <= '0;
              if (frame_end) begin
                position_count <= '0;
                stride_phase   <= '0;
                window_index   <= '0;
              end else begin
                position_count <= p_cur + 12'd1;
                if (p_full) begin
                  stride_phase <= ({1'b0, stride_phase} + 5'd1 >= s) ? 4'd0
                                  : stride_phase + 4'd1;
                end
                if (win_hit) window_index <= window_index + 12'd1;
              end
              if (win_hit) begin
                o_cnt <= '0;
                waddr <= '0;
                state <= ST_BIAS;
              end else begin
                state <= ST_IDLE;
              end
            end
          end
        end
        ST_BIAS: begin
          i_cnt <= '0;
          t_cnt <= '0;
          slot  <= slot_start;
          state <= ST_ISSUE;
        end
        ST_ISSUE: begin
          waddr <= waddr + 12'd1;
          if (t_last) begin
            t_cnt <= '0;
            slot  <= slot_start;
            i_cnt <= i_cnt + 4'd1;
            if (i_last) state <= ST_DRAIN;
          end else begin
            t_cnt <= t_cnt + 4'd1;
            slot  <= ({1'b0, slot} + 5'd1 == k) ? 4'd0 : slot + 4'd1;
          end
        end
        ST_DRAIN: begin
          if (!s1_v && !mac_busy) state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (res_load) begin
            result.out_channel  <= o_cnt;
            result.out_position <= out_pos;
            result.out_value    <= mac_value;
            result.saturated    <= mac_sat;
            result.last         <= o_last;
            if (o_last) begin
              state <= ST_IDLE;
            end else begin
              o_cnt <= o_cnt + 4'd1;
              state <= ST_BIAS;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_win_write_in_range: assert property (@(posedge clk) disable iff (rst)
    x_we |-> ({1'b0, ch_cur} < ic))
    else $error("window write beyond configured input channels");

  a_load_only_when_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!result_valid || !result_stall))
    else $error("result register overwritten while stalled");

  a_emit_after_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (!s1_v && !mac_busy))
    else $error("result taken while products still in flight");

  a_last_on_final_channel: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.last) |-> ({1'b0, result.out_channel} + 5'd1 == oc))
    else $error("last flag on wrong output channel");
`endif

endmodule
